>>> src/nirx_pkg.sv
`timescale 1ns / 1ps
// nirx_pkg: shared types, codes and window bounds for the nec ir frame receiver
// depends on nothing; imported by the top level, nirx_front and nirx_back
package nirx_pkg;

   // frame geometry
   localparam int FRAME_BITS_DEF = 32;
   localparam int BYTE_W = 8;
   localparam int TICKS_W = 16;

   // queue depths between the parts
   localparam int EVQ_DEPTH_DEF = 4;
   localparam int RSPQ_DEPTH_DEF = 4;

   // pair windows in 4 us ticks, bounds exclusive except the repeat space top
   localparam logic [TICKS_W-1:0] LEADER_MARK_LO = 16'd1750;
   localparam logic [TICKS_W-1:0] LEADER_MARK_HI = 16'd2750;
   localparam logic [TICKS_W-1:0] LEADER_SPACE_LO = 16'd800;
   localparam logic [TICKS_W-1:0] LEADER_SPACE_HI = 16'd1500;
   localparam logic [TICKS_W-1:0] REPEAT_SPACE_LO = 16'd400;
   localparam logic [TICKS_W-1:0] REPEAT_SPACE_HI = 16'd800;
   localparam logic [TICKS_W-1:0] BIT_MARK_LO = 16'd90;
   localparam logic [TICKS_W-1:0] BIT_MARK_HI = 16'd190;
   localparam logic [TICKS_W-1:0] ONE_SPACE_LO = 16'd375;
   localparam logic [TICKS_W-1:0] ONE_SPACE_HI = 16'd475;
   localparam logic [TICKS_W-1:0] ZERO_SPACE_LO = 16'd90;
   localparam logic [TICKS_W-1:0] ZERO_SPACE_HI = 16'd190;

   localparam logic [BYTE_W:0] CHECK_SUM = 9'h0FF;
   localparam logic [BYTE_W-1:0] REPEAT_MAX = 8'd255;

   // input command codes
   typedef enum logic [1:0] {
      CMD_PAIR = 2'd0,
      CMD_TIMEOUT = 2'd1,
      CMD_POLL = 2'd2
   } cmd_type;

   // classified events handed from front to back
   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_LEADER = 3'd1,
      EV_REPEAT = 3'd2,
      EV_ONE = 3'd3,
      EV_ZERO = 3'd4,
      EV_TIMEOUT = 3'd5,
      EV_POLL = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      TMR_NONE = 2'd0,
      TMR_ARM = 2'd1,
      TMR_STOP = 2'd2
   } timer_req_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READING = 2'd1,
      ST_READY = 2'd2,
      ST_READ = 2'd3
   } frame_state_type;

   typedef struct packed {
      logic frame_valid;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] address_inverse;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] command_inverse;
      logic [BYTE_W-1:0] repeat_count;
      timer_req_type timer_request;
      frame_state_type receiver_state;
   } rsp_item_type;

endpackage

>>> src/nec_ir_frame_receiver_unit.sv
`timescale 1ns / 1ps
// nec_ir_frame_receiver_unit: top level of the nec ir frame receiver
// depends on nirx_pkg, nirx_fifo, nirx_front, nirx_back
//
//   channel   direction  handshake           payload
//   req       in         push / full         req_cmd, req_mark_ticks, req_space_ticks
//   rsp       out        empty / pop         rsp_frame_valid .. rsp_receiver_state
//
// one item per cycle sustained while full is low; each item gives exactly one result item
// an accepted item reaches the rsp ports through the event queue, then the result queue
// the back part retires one event per cycle while the result queue has room, limited by the single frame state update
// reset clears the frame state and both queues; no clearing pass
// a stalled rsp side fills the result queue, then the event queue, then full rises
module nec_ir_frame_receiver_unit
   import nirx_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF,
   parameter int EVQ_DEPTH = EVQ_DEPTH_DEF,
   parameter int RSPQ_DEPTH = RSPQ_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [TICKS_W-1:0] req_mark_ticks,
   input  logic [TICKS_W-1:0] req_space_ticks,
   // result channel
   output logic               empty,
   input  logic               pop,
   output logic               rsp_frame_valid,
   output logic [BYTE_W-1:0]  rsp_address,
   output logic [BYTE_W-1:0]  rsp_address_inverse,
   output logic [BYTE_W-1:0]  rsp_command,
   output logic [BYTE_W-1:0]  rsp_command_inverse,
   output logic [BYTE_W-1:0]  rsp_repeat_count,
   output logic [1:0]         rsp_timer_request,
   output logic [1:0]         rsp_receiver_state
);

   // front: classify the incoming item into an event
   event_type front_ev;
   event_type back_ev;
   logic [$bits(event_type)-1:0] evq_out;
   logic evq_empty;

   // back side handshake
   logic rspq_full;
   logic back_go;
   rsp_item_type back_item;
   rsp_item_type rspq_item;

   nirx_front u_front (
      .req_cmd         (req_cmd),
      .req_mark_ticks  (req_mark_ticks),
      .req_space_ticks (req_space_ticks),
      .ev              (front_ev)
   );

   // event queue decouples classification from the frame state machine
   nirx_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (EVQ_DEPTH)
   ) u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_ev),
      .full      (full),
      .pop       (back_go),
      .pop_data  (evq_out),
      .empty     (evq_empty)
   );

   assign back_ev = event_type'(evq_out);

   // the back part retires an event only when its result has a slot
   assign back_go = !evq_empty && !rspq_full;

   nirx_back #(
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .go       (back_go),
      .ev       (back_ev),
      .rsp_item (back_item)
   );

   // result queue keeps finished items while the consumer stalls
   nirx_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (RSPQ_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (back_go),
      .push_data (back_item),
      .full      (rspq_full),
      .pop       (pop),
      .pop_data  (rspq_item),
      .empty     (empty)
   );

   // result fields
   assign rsp_frame_valid = rspq_item.frame_valid;
   assign rsp_address = rspq_item.address;
   assign rsp_address_inverse = rspq_item.address_inverse;
   assign rsp_command = rspq_item.command;
   assign rsp_command_inverse = rspq_item.command_inverse;
   assign rsp_repeat_count = rspq_item.repeat_count;
   assign rsp_timer_request = rspq_item.timer_request;
   assign rsp_receiver_state = rspq_item.receiver_state;

endmodule

>>> src/nirx_fifo.sv
`timescale 1ns / 1ps
// nirx_fifo: small first-in first-out queue of fixed-width items
// depends on nothing but its parameters
module nirx_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push_ok, pop_ok;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/nirx_front.sv
`timescale 1ns / 1ps
// nirx_front: sorts each incoming item into a receiver event by the pair windows
// depends on nirx_pkg
module nirx_front
   import nirx_pkg::*;
(
   input  logic [1:0]         req_cmd,
   input  logic [TICKS_W-1:0] req_mark_ticks,
   input  logic [TICKS_W-1:0] req_space_ticks,
   output event_type          ev
);

   logic leader_mark, bit_mark;
   logic leader_space, repeat_space, one_space, zero_space;

   assign leader_mark = (req_mark_ticks > LEADER_MARK_LO) && (req_mark_ticks < LEADER_MARK_HI);
   assign bit_mark = (req_mark_ticks > BIT_MARK_LO) && (req_mark_ticks < BIT_MARK_HI);
   assign leader_space = (req_space_ticks > LEADER_SPACE_LO)
                         && (req_space_ticks < LEADER_SPACE_HI);
   assign repeat_space = (req_space_ticks > REPEAT_SPACE_LO)
                         && (req_space_ticks <= REPEAT_SPACE_HI);
   assign one_space = (req_space_ticks > ONE_SPACE_LO) && (req_space_ticks < ONE_SPACE_HI);
   assign zero_space = (req_space_ticks > ZERO_SPACE_LO) && (req_space_ticks < ZERO_SPACE_HI);

   always_comb begin
      ev = EV_NONE;
      unique case (req_cmd)
         CMD_PAIR: begin
            priority if (leader_mark && leader_space) begin
               ev = EV_LEADER;
            end else if (leader_mark && repeat_space) begin
               ev = EV_REPEAT;
            end else if (bit_mark && one_space) begin
               ev = EV_ONE;
            end else if (bit_mark && zero_space) begin
               ev = EV_ZERO;
            end else begin
               ev = EV_NONE;
            end
         end
         CMD_TIMEOUT: ev = EV_TIMEOUT;
         CMD_POLL: ev = EV_POLL;
         default: ev = EV_NONE;
      endcase
   end

endmodule

>>> src/nirx_back.sv
`timescale 1ns / 1ps
// nirx_back: frame state machine, bit assembly, checks and repeat counting
// depends on nirx_pkg; fed by the event queue, feeds the result queue
module nirx_back
   import nirx_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  event_type    ev,
   output rsp_item_type rsp_item
);

   localparam int CW = $clog2(FRAME_BITS + 1);
   localparam int IW = $clog2(FRAME_BITS);

   frame_state_type state_ff, state_in;
   logic [CW-1:0] bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BYTE_W-1:0] repeat_ff, repeat_in;

   logic bit_take, last_bit, frame_good, frame_seen;
   logic [FRAME_BITS-1:0] frame_set;

   assign bit_take = (state_ff == ST_READING) && (bit_count_ff < CW'(FRAME_BITS));
   assign last_bit = (bit_count_ff == CW'(FRAME_BITS - 1));
   assign frame_seen = (state_ff == ST_READY) || (state_ff == ST_READ);

   always_comb begin
      frame_set = frame_ff;
      if (ev == EV_ONE) begin
         frame_set[bit_count_ff[IW-1:0]] = 1'b1;
      end
   end

   assign frame_good =
      ({1'b0, frame_set[BYTE_W-1:0]} + {1'b0, frame_set[2*BYTE_W-1:BYTE_W]} == CHECK_SUM)
      && ({1'b0, frame_set[3*BYTE_W-1:2*BYTE_W]}
          + {1'b0, frame_set[4*BYTE_W-1:3*BYTE_W]} == CHECK_SUM);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (ev)
         EV_LEADER: state_in = ST_READING;
         EV_REPEAT: state_in = frame_seen ? ST_READY : ST_IDLE;
         EV_ONE, EV_ZERO: begin
            if (bit_take && last_bit && frame_good) begin
               state_in = ST_READY;
            end
         end
         EV_TIMEOUT: state_in = ST_IDLE;
         EV_POLL: begin
            if (state_ff == ST_READY) begin
               state_in = ST_READ;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // datapath and result
   always_comb begin
      bit_count_in = bit_count_ff;
      frame_in = frame_ff;
      repeat_in = repeat_ff;
      rsp_item = '0;
      rsp_item.timer_request = TMR_NONE;
      unique case (ev)
         EV_LEADER: begin
            bit_count_in = '0;
            frame_in = '0;
            repeat_in = '0;
         end
         EV_REPEAT: begin
            if (frame_seen) begin
               if (repeat_ff != REPEAT_MAX) begin
                  repeat_in = repeat_ff + 1'b1;
               end
               rsp_item.timer_request = TMR_ARM;
            end else begin
               bit_count_in = '0;
               frame_in = '0;
               repeat_in = '0;
               rsp_item.timer_request = TMR_STOP;
            end
         end
         EV_ONE, EV_ZERO: begin
            if (bit_take) begin
               frame_in = frame_set;
               bit_count_in = bit_count_ff + 1'b1;
               if (last_bit && frame_good) begin
                  rsp_item.timer_request = TMR_ARM;
               end
            end
         end
         EV_TIMEOUT: begin
            bit_count_in = '0;
            frame_in = '0;
            repeat_in = '0;
            rsp_item.timer_request = TMR_STOP;
         end
         EV_POLL: begin
            if (state_ff == ST_READY) begin
               rsp_item.frame_valid = 1'b1;
               rsp_item.address = frame_ff[BYTE_W-1:0];
               rsp_item.address_inverse = frame_ff[2*BYTE_W-1:BYTE_W];
               rsp_item.command = frame_ff[3*BYTE_W-1:2*BYTE_W];
               rsp_item.command_inverse = frame_ff[4*BYTE_W-1:3*BYTE_W];
               rsp_item.repeat_count = repeat_ff;
            end
         end
         default: begin
            bit_count_in = bit_count_ff;
         end
      endcase
      rsp_item.receiver_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_count_ff <= '0;
         frame_ff <= '0;
         repeat_ff <= '0;
      end else if (go) begin
         state_ff <= state_in;
         bit_count_ff <= bit_count_in;
         frame_ff <= frame_in;
         repeat_ff <= repeat_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= CW'(FRAME_BITS))
      else $error("bit count ran past the frame length");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READY || state_ff == ST_READ) |-> bit_count_ff == CW'(FRAME_BITS))
      else $error("frame ready without a full bit count");

   a_poll_marks_read: assert property (@(posedge clock) disable iff (reset)
      (go && rsp_item.frame_valid) |=> state_ff == ST_READ)
      else $error("handed out frame not marked read");

   a_leader_clears: assert property (@(posedge clock) disable iff (reset)
      (go && ev == EV_LEADER) |=> (bit_count_ff == '0 && repeat_ff == '0
                                   && state_ff == ST_READING))
      else $error("leader did not restart the frame");

endmodule
